FILE: design/int7s_pkg.sv
// Shared types, constants and helper functions for the seven-segment formatter.
package int7s_pkg;

  localparam logic [1:0] ACT_UNSIGNED = 2'd0;
  localparam logic [1:0] ACT_SIGNED   = 2'd1;
  localparam logic [1:0] ACT_LABEL    = 2'd2;

  localparam int UNSIGNED_MAX = 9999;
  localparam int SIGNED_MAX   = 999;
  localparam int SIGNED_MIN   = -999;

  localparam logic [3:0] GLYPH_MINUS = 4'd10;
  localparam logic [3:0] GLYPH_BLANK = 4'd11;
  localparam logic [7:0] COLON_BIT   = 8'b1000_0000;

  // floor(x / 10) == (x * RECIP10) >> RECIP_SHIFT for every x below 43699
  localparam int MAG_W       = 14;
  localparam int RECIP10     = 52429;
  localparam int RECIP_SHIFT = 19;
  localparam int PROD_W      = MAG_W + 16;

  typedef struct packed {
    logic [1:0]         action;
    logic signed [31:0] number;
    logic [3:0]         label_right;
    logic [3:0]         label_second;
    logic [3:0]         label_third;
    logic [3:0]         label_left;
    logic               colon_lit;
  } req_t;

  typedef struct packed {
    logic [7:0] segments_right;
    logic [7:0] segments_second;
    logic [7:0] segments_third;
    logic [7:0] segments_left;
  } rsp_t;

  // Word state between pipeline stages
  typedef struct packed {
    logic [1:0]       action;
    logic             neg;
    logic             colon;
    logic [3:0]       lbl0;
    logic [3:0]       lbl1;
    logic [3:0]       lbl2;
    logic [3:0]       lbl3;
    logic [MAG_W-1:0] quo;
    logic [3:0]       dig0;
    logic [3:0]       dig1;
    logic [3:0]       dig2;
  } stage_t;

  typedef struct packed {
    logic [MAG_W-1:0] q;
    logic [3:0]       r;
  } divmod_t;

  function automatic divmod_t div10(input logic [MAG_W-1:0] x);
    logic [PROD_W-1:0] prod;
    logic [MAG_W-1:0]  q;
    logic [MAG_W-1:0]  t;
    divmod_t           res;
    prod  = {16'b0, x} * PROD_W'(RECIP10);
    q     = MAG_W'(prod >> RECIP_SHIFT);
    t     = x - ((q << 3) + (q << 1));
    res.q = q;
    res.r = t[3:0];
    return res;
  endfunction

  function automatic logic [6:0] glyph_bits(input logic [3:0] idx);
    logic [6:0] seg;
    case (idx)
      4'd0:        seg = 7'b011_1111;
      4'd1:        seg = 7'b000_0110;
      4'd2:        seg = 7'b101_1011;
      4'd3:        seg = 7'b100_1111;
      4'd4:        seg = 7'b110_0110;
      4'd5:        seg = 7'b110_1101;
      4'd6:        seg = 7'b111_1101;
      4'd7:        seg = 7'b000_0111;
      4'd8:        seg = 7'b111_1111;
      4'd9:        seg = 7'b110_1111;
      GLYPH_MINUS: seg = 7'b100_0000;
      default:     seg = 7'b000_0000;
    endcase
    return seg;
  endfunction

endpackage

FILE: design/int7s_if.sv
// Valid/ready stream interfaces for request and result words.
interface int7s_req_if import int7s_pkg::*; ();
  logic valid;
  logic ready;
  req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface int7s_rsp_if import int7s_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

FILE: design/integer_to_seven_segment.sv
// Four-digit seven-segment formatter: pipelined clamp, decimal split and glyph lookup.
//
// Each request word yields one result word of four active-high segment bytes
// (bits 0-6 = segments A-G, bit 7 = colon). Action 0 clamps the number to
// 0..9999 and shows four digits with leading zeros; action 1 clamps to
// -999..999, blanks leading zeros and places a minus left of the top digit;
// action 2 shows four raw glyph indices (0-9, 10 minus, 11 and above blank);
// action 3 shows blank. The block is a five-stage pipeline: clamp, then one
// divide-by-ten (reciprocal multiply) per stage for three stages, then the
// glyph lookup into the output register. The clamp stage loads at the
// accepting edge, and the sustained rate is one word per clock while the
// result side does not stall. Every stage holds its own valid bit and
// advances whenever the stage after it is empty or moving, so bubbles are
// squeezed out while the result side stalls and new words keep entering
// until the pipeline is full. There is no state beyond the pipeline;
// reset only clears the valid bits.
module integer_to_seven_segment import int7s_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  int7s_req_if.sink   req,
  int7s_rsp_if.source rsp
);

  localparam int STAGES = 4;

  stage_t           s1, s2, s3, s4;
  stage_t           s1_next, s2_next, s3_next, s4_next;
  logic [STAGES:1]  v;
  logic [STAGES:1]  en;
  logic             out_valid;
  rsp_t             out_word;
  rsp_t             out_word_next;
  logic             en_out;

  // Per-stage advance: a stage may load when it is empty or its word moves on.
  assign en_out = !out_valid || rsp.ready;
  assign en[4]  = !v[4] || en_out;
  assign en[3]  = !v[3] || en[4];
  assign en[2]  = !v[2] || en[3];
  assign en[1]  = !v[1] || en[2];

  assign req.ready   = en[1];
  assign rsp.valid   = out_valid;
  assign rsp.payload = out_word;

  // Stage 1: clamp to the displayable range and take the magnitude.
  always_comb begin
    logic signed [31:0] num;
    logic [10:0]        neg_low;
    num            = req.payload.number;
    neg_low        = ~num[10:0] + 11'd1;
    s1_next        = '0;
    s1_next.action = req.payload.action;
    s1_next.colon  = req.payload.colon_lit;
    s1_next.lbl0   = req.payload.label_right;
    s1_next.lbl1   = req.payload.label_second;
    s1_next.lbl2   = req.payload.label_third;
    s1_next.lbl3   = req.payload.label_left;
    case (req.payload.action)
      ACT_UNSIGNED: begin
        if (num < 0) begin
          s1_next.quo = '0;
        end else if (num > UNSIGNED_MAX) begin
          s1_next.quo = MAG_W'(UNSIGNED_MAX);
        end else begin
          s1_next.quo = num[MAG_W-1:0];
        end
      end
      ACT_SIGNED: begin
        if (num > SIGNED_MAX) begin
          s1_next.quo = MAG_W'(SIGNED_MAX);
        end else if (num < SIGNED_MIN) begin
          s1_next.neg = 1'b1;
          s1_next.quo = MAG_W'(SIGNED_MAX);
        end else if (num < 0) begin
          s1_next.neg = 1'b1;
          s1_next.quo = {3'b0, neg_low};
        end else begin
          s1_next.quo = {3'b0, num[10:0]};
        end
      end
      default: begin
        s1_next.quo = '0;
      end
    endcase
  end

  // Stages 2..4: peel one decimal digit each, ones first.
  always_comb begin
    divmod_t dm2, dm3, dm4;
    dm2          = div10(s1.quo);
    s2_next      = s1;
    s2_next.quo  = dm2.q;
    s2_next.dig0 = dm2.r;
    dm3          = div10(s2.quo);
    s3_next      = s2;
    s3_next.quo  = dm3.q;
    s3_next.dig1 = dm3.r;
    dm4          = div10(s3.quo);
    s4_next      = s3;
    s4_next.quo  = dm4.q;
    s4_next.dig2 = dm4.r;
  end

  // Output stage: pick glyph indices per action and look up segments.
  always_comb begin
    logic [3:0] idx0, idx1, idx2, idx3;
    logic       ge10, ge100;
    logic [7:0] colon;
    ge10  = (s4.dig1 != 4'd0) || (s4.dig2 != 4'd0);
    ge100 = (s4.dig2 != 4'd0);
    colon = s4.colon ? COLON_BIT : 8'd0;
    case (s4.action)
      ACT_UNSIGNED: begin
        idx0 = s4.dig0;
        idx1 = s4.dig1;
        idx2 = s4.dig2;
        idx3 = s4.quo[3:0];
      end
      ACT_SIGNED: begin
        idx0 = s4.dig0;
        idx1 = ge10  ? s4.dig1 : GLYPH_BLANK;
        idx2 = ge100 ? s4.dig2 : GLYPH_BLANK;
        idx3 = GLYPH_BLANK;
        if (s4.neg) begin
          if (ge100) begin
            idx3 = GLYPH_MINUS;
          end else if (ge10) begin
            idx2 = GLYPH_MINUS;
          end else begin
            idx1 = GLYPH_MINUS;
          end
        end
      end
      ACT_LABEL: begin
        idx0 = s4.lbl0;
        idx1 = s4.lbl1;
        idx2 = s4.lbl2;
        idx3 = s4.lbl3;
      end
      default: begin
        idx0 = GLYPH_BLANK;
        idx1 = GLYPH_BLANK;
        idx2 = GLYPH_BLANK;
        idx3 = GLYPH_BLANK;
      end
    endcase
    out_word_next.segments_right  = {1'b0, glyph_bits(idx0)} | colon;
    out_word_next.segments_second = {1'b0, glyph_bits(idx1)} | colon;
    out_word_next.segments_third  = {1'b0, glyph_bits(idx2)} | colon;
    out_word_next.segments_left   = {1'b0, glyph_bits(idx3)} | colon;
  end

  // Valid bits: reset clears them; a stage takes its upstream valid when enabled.
  always_ff @(posedge clk) begin
    if (rst) begin
      v         <= '0;
      out_valid <= 1'b0;
    end else begin
      if (en[1]) v[1] <= req.valid;
      if (en[2]) v[2] <= v[1];
      if (en[3]) v[3] <= v[2];
      if (en[4]) v[4] <= v[3];
      if (en_out) out_valid <= v[4];
    end
  end

  // Payload registers: load only when the stage advances, hold otherwise.
  always_ff @(posedge clk) begin
    if (en[1]) s1 <= s1_next;
    if (en[2]) s2 <= s2_next;
    if (en[3]) s3 <= s3_next;
    if (en[4]) s4 <= s4_next;
    if (en_out) out_word <= out_word_next;
  end

`ifndef SYNTHESIS
  // An accepted word lands in the first stage.
  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> v[1])
    else $error("accepted word lost at stage 1");

  // A stalled stage 4 keeps its word intact.
  a_stage4_hold: assert property (@(posedge clk) disable iff (rst)
    v[4] && !en[4] |=> v[4] && $stable(s4))
    else $error("stage 4 word changed while stalled");

  // The colon bit is common to all four bytes.
  a_colon_common: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> (rsp.payload.segments_right[7] == rsp.payload.segments_left[7]) &&
                  (rsp.payload.segments_second[7] == rsp.payload.segments_left[7]) &&
                  (rsp.payload.segments_third[7] == rsp.payload.segments_left[7]))
    else $error("colon bit differs between digits");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !rsp.valid && (v == '0))
    else $error("pipeline not empty after reset");
`endif

endmodule
